// ----- design/fla_pkg.sv -----
// Shared types and constants of the free list block allocator.
`timescale 1ns / 1ps
package fla_pkg;

  localparam int DEF_MAX_EXTENTS = 32;
  localparam int DEF_ADDR_BITS   = 16;
  localparam int DEF_OWNER_BITS  = 8;

  localparam int PSIZE_BITS = 17;
  localparam int PID_BITS   = 8;
  localparam int REQ_BITS   = 17;
  localparam int OP_BITS    = 2;
  localparam int STAT_BITS  = 2;

  localparam logic [PSIZE_BITS-1:0] PSIZE_RESET = 17'd65536;

  localparam logic [OP_BITS-1:0] OP_ALLOC    = 2'd0;
  localparam logic [OP_BITS-1:0] OP_RELEASE  = 2'd1;
  localparam logic [OP_BITS-1:0] OP_COALESCE = 2'd2;
  localparam logic [OP_BITS-1:0] OP_INIT     = 2'd3;

  localparam logic [STAT_BITS-1:0] ST_OK     = 2'd0;
  localparam logic [STAT_BITS-1:0] ST_NO_FIT = 2'd1;
  localparam logic [STAT_BITS-1:0] ST_NO_PID = 2'd2;
  localparam logic [STAT_BITS-1:0] ST_FULL   = 2'd3;

  // Register byte addresses
  localparam logic [2:0] REG_PSIZE  = 3'd0;
  localparam logic [2:0] REG_POLICY = 3'd4;

  typedef enum logic [1:0] {
    TAB_NONE,
    TAB_WRITE,
    TAB_INSERT,
    TAB_REMOVE
  } tab_op_e;

endpackage

// ----- design/fla_tab.sv -----
// Extent table: register array with one read port, write, insert and remove with shift.
`timescale 1ns / 1ps
module fla_tab import fla_pkg::*; #(
  parameter int DEPTH = DEF_MAX_EXTENTS,
  parameter int W     = 2 * DEF_ADDR_BITS
) (
  input  logic                     clk_i,
  input  tab_op_e                  op_i,
  input  logic [$clog2(DEPTH)-1:0] pos_i,
  input  logic [W-1:0]             wdata_i,
  input  logic [$clog2(DEPTH)-1:0] rd_idx_i,
  output logic [W-1:0]             rd_data_o
);

  localparam int IW = $clog2(DEPTH);

  logic [W-1:0] mem_q [DEPTH];

  for (genvar k = 0; k < DEPTH; k++) begin : g_ent
    localparam int KP = (k == 0) ? 0 : k - 1;
    localparam int KN = (k == DEPTH - 1) ? k : k + 1;
    localparam logic [IW-1:0] KI = IW'(k);

    always_ff @(posedge clk_i) begin
      unique case (op_i)
        TAB_WRITE: begin
          if (KI == pos_i) mem_q[k] <= wdata_i;
        end
        TAB_INSERT: begin
          if (KI == pos_i) mem_q[k] <= wdata_i;
          else if (KI > pos_i) mem_q[k] <= mem_q[KP];
        end
        TAB_REMOVE: begin
          if (KI >= pos_i) mem_q[k] <= mem_q[KN];
        end
        default: begin
        end
      endcase
    end
  end

  assign rd_data_o = mem_q[rd_idx_i];

endmodule

// ----- design/free_list_block_allocator_top.sv -----
// Top level of the free list block allocator.
// Usage:
//   One address partition is managed as a free extent table and an address-ordered
//   used extent table. Items enter on the s_axis channel: tuser carries the
//   operation (allocate, release, coalesce, initialize), tdata the pid and request
//   size. Every item yields exactly one result item on m_axis: tuser the status,
//   tdata the extent start/end and both table fill counts.
//   APB registers pool size (addr 0) and fit_policy (addr 4) are written while the
//   block is idle (user's duty, not enforced); the pool size acts at initialize.
// Steps (one table entry visited per cycle by a shared compare unit under the
//   sequencer), from accept to next ready:
//   allocate   fit scan, used-table scan, free placement
//   release    owner scan of the used table, free placement
//   coalesce   insertion sort by start address, then merge pass
//   initialize free table reset from the pool size
//   s_axis_tready is high only while the sequencer is idle.
// Reset: both tables are empty, pool size = 65536, fit_policy = 0.
// Stall: the result sits in an output register; a new item may be taken while it
//   waits, and the sequencer holds in its final step until the register frees.
module free_list_block_allocator_top import fla_pkg::*; #(
  parameter int MAX_EXTENTS = DEF_MAX_EXTENTS,
  parameter int ADDR_BITS   = DEF_ADDR_BITS,
  parameter int OWNER_BITS  = DEF_OWNER_BITS,
  localparam int CW   = $clog2(MAX_EXTENTS + 1),
  localparam int OUTW = ((2 * ADDR_BITS + 2 * CW + 7) / 8) * 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  // APB configuration
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [2:0]      paddr,
  input  logic [31:0]     pwdata,
  output logic [31:0]     prdata,
  output logic            pready,
  // input items
  input  logic            s_axis_tvalid,
  output logic            s_axis_tready,
  input  logic [31:0]     s_axis_tdata,  // pid[7:0], request_size[24:8], zeros
  input  logic [1:0]      s_axis_tuser,  // operation
  // result items
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  output logic [OUTW-1:0] m_axis_tdata,  // block_start, block_end, free_count,
                                         // alloc_count, zeros
  output logic [1:0]      m_axis_tuser   // status
);

  localparam int A    = ADDR_BITS;
  localparam int O    = OWNER_BITS;
  localparam int IW   = $clog2(MAX_EXTENTS);
  localparam int CMPW = (A + 1 > REQ_BITS) ? A + 1 : REQ_BITS;
  localparam int FW   = 2 * A;
  localparam int UW   = 2 * A + O;
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_EXTENTS);
  localparam logic [CW-1:0] CNT_ONE = CW'(1);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_ASCAN  = 4'd1;
  localparam logic [3:0] S_USCAN  = 4'd2;
  localparam logic [3:0] S_FPLACE = 4'd3;
  localparam logic [3:0] S_RSCAN  = 4'd4;
  localparam logic [3:0] S_CLOAD  = 4'd5;
  localparam logic [3:0] S_CCMP   = 4'd6;
  localparam logic [3:0] S_MINIT  = 4'd7;
  localparam logic [3:0] S_MSTEP  = 4'd8;
  localparam logic [3:0] S_MEND   = 4'd9;
  localparam logic [3:0] S_DONE   = 4'd10;

  // ---------------- configuration ----------------
  logic [PSIZE_BITS-1:0] psize_q;
  logic                  policy_q;
  logic                  cfg_wr;

  assign cfg_wr = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      psize_q  <= PSIZE_RESET;
      policy_q <= 1'b0;
    end else if (cfg_wr) begin
      if (paddr == REG_PSIZE) psize_q <= pwdata[PSIZE_BITS-1:0];
      if (paddr == REG_POLICY) policy_q <= pwdata[0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == REG_PSIZE) prdata = 32'(psize_q);
    else if (paddr == REG_POLICY) prdata = 32'(policy_q);
  end

  // ---------------- sequencer state ----------------
  logic [3:0]           state_q, state_d;
  logic [O-1:0]         own_q, own_d;
  logic [REQ_BITS-1:0]  req_q, req_d;
  logic [CW-1:0]        idx_q, idx_d, j_q, j_d, n_q, n_d;
  logic [A-1:0]         s_q, s_d, e_q, e_d, ks_q, ks_d, ke_q, ke_d;
  logic                 rem_q, rem_d;
  logic [STAT_BITS-1:0] stat_q, stat_d;
  logic [CW-1:0]        fcnt_q, fcnt_d, ucnt_q, ucnt_d;
  logic                 ov_q, ov_d;
  logic [STAT_BITS-1:0] o_stat_q, o_stat_d;
  logic [A-1:0]         o_s_q, o_s_d, o_e_q, o_e_d;
  logic [CW-1:0]        o_f_q, o_f_d, o_u_q, o_u_d;

  // table ports
  tab_op_e       f_op, u_op;
  logic [IW-1:0] f_pos, u_pos, f_ridx;
  logic [FW-1:0] f_wd, f_rd;
  logic [UW-1:0] u_wd, u_rd;
  logic [A-1:0]  fr_s, fr_e, ur_s, ur_e;
  logic [O-1:0]  ur_o;

  assign fr_s = f_rd[A-1:0];
  assign fr_e = f_rd[FW-1:A];
  assign ur_s = u_rd[A-1:0];
  assign ur_e = u_rd[2*A-1:A];
  assign ur_o = u_rd[UW-1:2*A];

  fla_tab #(.DEPTH(MAX_EXTENTS), .W(FW)) u_free (
    .clk_i    (clk_i),
    .op_i     (f_op),
    .pos_i    (f_pos),
    .wdata_i  (f_wd),
    .rd_idx_i (f_ridx),
    .rd_data_o(f_rd)
  );

  fla_tab #(.DEPTH(MAX_EXTENTS), .W(UW)) u_used (
    .clk_i    (clk_i),
    .op_i     (u_op),
    .pos_i    (u_pos),
    .wdata_i  (u_wd),
    .rd_idx_i (idx_q[IW-1:0]),
    .rd_data_o(u_rd)
  );

  // ---------------- datapath helpers ----------------
  logic [A:0]      fr_size, k_size, ke_inc;
  logic [CMPW-1:0] alloc_sum, ps_m1;
  logic [A-1:0]    alloc_end, init_end;
  logic [CW-1:0]   jm1;

  assign fr_size   = {1'b0, fr_e} - {1'b0, fr_s} + (A + 1)'(1);
  assign k_size    = {1'b0, ke_q} - {1'b0, ks_q} + (A + 1)'(1);
  assign ke_inc    = {1'b0, ke_q} + (A + 1)'(1);
  assign alloc_sum = CMPW'(fr_s) + CMPW'(req_q) - CMPW'(1);
  assign alloc_end = alloc_sum[A-1:0];
  assign ps_m1     = CMPW'(psize_q) - CMPW'(1);
  // partition larger than the address span saturates to the full span
  assign init_end  = ((ps_m1 >> A) != '0) ? '1 : ps_m1[A-1:0];
  assign jm1       = j_q - CNT_ONE;

  // shared compare unit, operands chosen by the sequencer step
  logic [CMPW-1:0] cmp_a, cmp_b;
  logic            cmp_gt, cmp_eq;

  always_comb begin
    cmp_a = '0;
    cmp_b = '0;
    unique case (state_q)
      S_ASCAN:  begin cmp_a = CMPW'(fr_size); cmp_b = CMPW'(req_q); end
      S_USCAN:  begin cmp_a = CMPW'(ur_s);    cmp_b = CMPW'(s_q);   end
      S_FPLACE: begin cmp_a = CMPW'(fr_size); cmp_b = CMPW'(k_size); end
      S_RSCAN:  begin cmp_a = CMPW'(ur_o);    cmp_b = CMPW'(own_q); end
      S_CCMP:   begin cmp_a = CMPW'(fr_s);    cmp_b = CMPW'(ks_q);  end
      S_MSTEP:  begin cmp_a = CMPW'(ke_inc);  cmp_b = CMPW'(fr_s);  end
      default: begin
      end
    endcase
  end

  assign cmp_gt = cmp_a > cmp_b;
  assign cmp_eq = cmp_a == cmp_b;

  assign s_axis_tready = (state_q == S_IDLE);

  // ---------------- sequencer ----------------
  always_comb begin
    state_d  = state_q;
    own_d    = own_q;
    req_d    = req_q;
    idx_d    = idx_q;
    j_d      = j_q;
    n_d      = n_q;
    s_d      = s_q;
    e_d      = e_q;
    ks_d     = ks_q;
    ke_d     = ke_q;
    rem_d    = rem_q;
    stat_d   = stat_q;
    fcnt_d   = fcnt_q;
    ucnt_d   = ucnt_q;
    ov_d     = ov_q;
    o_stat_d = o_stat_q;
    o_s_d    = o_s_q;
    o_e_d    = o_e_q;
    o_f_d    = o_f_q;
    o_u_d    = o_u_q;
    f_op     = TAB_NONE;
    f_pos    = idx_q[IW-1:0];
    f_wd     = {ke_q, ks_q};
    f_ridx   = idx_q[IW-1:0];
    u_op     = TAB_NONE;
    u_pos    = idx_q[IW-1:0];
    u_wd     = {own_q, e_q, s_q};

    if (ov_q && m_axis_tready) ov_d = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          own_d  = O'(s_axis_tdata[PID_BITS-1:0]);
          req_d  = s_axis_tdata[PID_BITS +: REQ_BITS];
          idx_d  = '0;
          stat_d = ST_OK;
          s_d    = '0;
          e_d    = '0;
          unique case (s_axis_tuser)
            OP_ALLOC: begin
              if (fcnt_q == '0) begin
                stat_d  = ST_NO_FIT;
                state_d = S_DONE;
              end else begin
                state_d = S_ASCAN;
              end
            end
            OP_RELEASE: begin
              if (ucnt_q == '0) begin
                stat_d  = ST_NO_PID;
                state_d = S_DONE;
              end else begin
                state_d = S_RSCAN;
              end
            end
            OP_COALESCE: begin
              if (fcnt_q <= CNT_ONE) begin
                state_d = S_DONE;
              end else begin
                idx_d   = CNT_ONE;
                state_d = S_CLOAD;
              end
            end
            OP_INIT: begin
              ucnt_d = '0;
              if (psize_q == '0) begin
                fcnt_d = '0;
              end else begin
                f_op   = TAB_WRITE;
                f_pos  = '0;
                f_wd   = {init_end, {A{1'b0}}};
                fcnt_d = CNT_ONE;
              end
              state_d = S_DONE;
            end
            default: begin
            end
          endcase
        end
      end

      // first free extent that covers the request
      S_ASCAN: begin
        if (req_q != '0 && (cmp_gt || cmp_eq)) begin
          if (ucnt_q == CNT_MAX) begin
            stat_d  = ST_FULL;
            state_d = S_DONE;
          end else begin
            s_d     = fr_s;
            e_d     = alloc_end;
            ks_d    = alloc_end + A'(1);
            ke_d    = fr_e;
            rem_d   = (alloc_end != fr_e);
            f_op    = TAB_REMOVE;
            fcnt_d  = fcnt_q - CNT_ONE;
            idx_d   = '0;
            state_d = S_USCAN;
          end
        end else if (idx_q + CNT_ONE == fcnt_q) begin
          stat_d  = ST_NO_FIT;
          state_d = S_DONE;
        end else begin
          idx_d = idx_q + CNT_ONE;
        end
      end

      // address-ordered insert into the used table
      S_USCAN: begin
        if (idx_q == ucnt_q || cmp_gt) begin
          u_op   = TAB_INSERT;
          ucnt_d = ucnt_q + CNT_ONE;
          idx_d  = '0;
          state_d = rem_q ? S_FPLACE : S_DONE;
        end else begin
          idx_d = idx_q + CNT_ONE;
        end
      end

      // place {ks,ke}: append, or ascending size in best fit
      S_FPLACE: begin
        if (!policy_q || idx_q == fcnt_q || cmp_gt) begin
          f_op    = TAB_INSERT;
          f_pos   = policy_q ? idx_q[IW-1:0] : fcnt_q[IW-1:0];
          fcnt_d  = fcnt_q + CNT_ONE;
          state_d = S_DONE;
        end else begin
          idx_d = idx_q + CNT_ONE;
        end
      end

      S_RSCAN: begin
        if (idx_q == ucnt_q) begin
          stat_d  = ST_NO_PID;
          state_d = S_DONE;
        end else if (cmp_eq) begin
          if (fcnt_q == CNT_MAX) begin
            stat_d  = ST_FULL;
            state_d = S_DONE;
          end else begin
            s_d     = ur_s;
            e_d     = ur_e;
            ks_d    = ur_s;
            ke_d    = ur_e;
            u_op    = TAB_REMOVE;
            ucnt_d  = ucnt_q - CNT_ONE;
            idx_d   = '0;
            state_d = S_FPLACE;
          end
        end else begin
          idx_d = idx_q + CNT_ONE;
        end
      end

      // insertion sort by start address
      S_CLOAD: begin
        ks_d    = fr_s;
        ke_d    = fr_e;
        j_d     = idx_q;
        state_d = S_CCMP;
      end

      S_CCMP: begin
        f_ridx = jm1[IW-1:0];
        f_pos  = j_q[IW-1:0];
        f_op   = TAB_WRITE;
        if (j_q != '0 && cmp_gt) begin
          f_wd = f_rd;
          j_d  = jm1;
        end else begin
          idx_d = idx_q + CNT_ONE;
          state_d = (idx_q + CNT_ONE == fcnt_q) ? S_MINIT : S_CLOAD;
        end
      end

      // merge touching neighbors
      S_MINIT: begin
        f_ridx  = '0;
        ks_d    = fr_s;
        ke_d    = fr_e;
        n_d     = '0;
        idx_d   = CNT_ONE;
        state_d = S_MSTEP;
      end

      S_MSTEP: begin
        if (cmp_eq) begin
          ke_d = fr_e;
        end else begin
          f_op  = TAB_WRITE;
          f_pos = n_q[IW-1:0];
          n_d   = n_q + CNT_ONE;
          ks_d  = fr_s;
          ke_d  = fr_e;
        end
        if (idx_q + CNT_ONE == fcnt_q) state_d = S_MEND;
        else idx_d = idx_q + CNT_ONE;
      end

      S_MEND: begin
        f_op    = TAB_WRITE;
        f_pos   = n_q[IW-1:0];
        fcnt_d  = n_q + CNT_ONE;
        state_d = S_DONE;
      end

      S_DONE: begin
        if (!ov_q || m_axis_tready) begin
          ov_d     = 1'b1;
          o_stat_d = stat_q;
          o_s_d    = s_q;
          o_e_d    = e_q;
          o_f_d    = fcnt_q;
          o_u_d    = ucnt_q;
          state_d  = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      fcnt_q  <= '0;
      ucnt_q  <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      fcnt_q  <= fcnt_d;
      ucnt_q  <= ucnt_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    own_q    <= own_d;
    req_q    <= req_d;
    idx_q    <= idx_d;
    j_q      <= j_d;
    n_q      <= n_d;
    s_q      <= s_d;
    e_q      <= e_d;
    ks_q     <= ks_d;
    ke_q     <= ke_d;
    rem_q    <= rem_d;
    stat_q   <= stat_d;
    o_stat_q <= o_stat_d;
    o_s_q    <= o_s_d;
    o_e_q    <= o_e_d;
    o_f_q    <= o_f_d;
    o_u_q    <= o_u_d;
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tuser  = o_stat_q;
  assign m_axis_tdata  = OUTW'({o_u_q, o_f_q, o_e_q, o_s_q});

endmodule

// ----- design/fla_chk.sv -----
// Port-level checker for the free list block allocator, bound to the top level.
`timescale 1ns / 1ps
module fla_chk import fla_pkg::*; #(
  parameter int MAX_EXTENTS = DEF_MAX_EXTENTS,
  parameter int ADDR_BITS   = DEF_ADDR_BITS,
  parameter int OWNER_BITS  = DEF_OWNER_BITS,
  localparam int CW   = $clog2(MAX_EXTENTS + 1),
  localparam int OUTW = ((2 * ADDR_BITS + 2 * CW + 7) / 8) * 8
) (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            s_axis_tvalid,
  input logic            s_axis_tready,
  input logic            m_axis_tvalid,
  input logic            m_axis_tready,
  input logic [OUTW-1:0] m_axis_tdata,
  input logic [1:0]      m_axis_tuser
);

  localparam int A = ADDR_BITS;
  localparam int OB = OWNER_BITS;
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_EXTENTS);

  logic [A-1:0]  c_s, c_e;
  logic [CW-1:0] c_f, c_u;

  assign c_s = m_axis_tdata[A-1:0];
  assign c_e = m_axis_tdata[2*A-1:A];
  assign c_f = m_axis_tdata[2*A +: CW];
  assign c_u = m_axis_tdata[2*A+CW +: CW];

  // s_axis_tready is low in the cycle after an item is accepted
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("accepted two items in consecutive cycles");

  // a failed operation reports no extent
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != ST_OK |-> c_s == '0 && c_e == '0)
    else $error("extent reported with failing status (owner bits %0d)", OB);

  // fill counts never exceed the table depth
  a_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> c_f <= CNT_MAX && c_u <= CNT_MAX)
    else $error("table count out of range");

  // a stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

endmodule

bind free_list_block_allocator_top fla_chk #(
  .MAX_EXTENTS(MAX_EXTENTS),
  .ADDR_BITS  (ADDR_BITS),
  .OWNER_BITS (OWNER_BITS)
) u_fla_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser)
);

// ----- tb/sv/free_list_block_allocator_checker.sv -----
// Checker for the free list block allocator: extent table predictor and result compare.
`timescale 1ns / 1ps
module free_list_block_allocator_checker import fla_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [2:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  input  logic        pready_i,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [31:0] s_tdata_i,   // pid[7:0], request_size[24:8], zeros
  input  logic [1:0]  s_tuser_i,   // operation
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [47:0] m_tdata_i,   // block_start, block_end, free_count, alloc_count
  input  logic [1:0]  m_tuser_i,   // status
  output int          fail_count_o,
  output int          pending_o
);

  localparam int NEXT = DEF_MAX_EXTENTS;

  typedef struct packed {
    logic [STAT_BITS-1:0] status;
    logic [15:0]          bstart;
    logic [15:0]          bend;
    logic [5:0]           nfree;
    logic [5:0]           nused;
  } extent_result_t;

  extent_result_t result_q[$];

  logic [15:0] fs [NEXT];
  logic [15:0] fe [NEXT];
  logic [15:0] us [NEXT];
  logic [15:0] ue [NEXT];
  logic [7:0]  uo [NEXT];
  int          fn, un;
  logic [16:0] psize;
  logic        best_fit;
  int          fails;

  assign fail_count_o = fails;
  assign pending_o    = result_q.size();

  task automatic report(input string what, input int want, input int got);
    if (fails < 40) $display("mismatch %s: expected %0d got %0d", what, want, got);
    fails++;
  endtask

  task automatic free_place(input int s, input int e);
    int pos;
    pos = fn;
    if (best_fit) begin
      for (int i = 0; i < fn; i++) begin
        if (int'(fe[i]) - int'(fs[i]) + 1 > e - s + 1) begin
          pos = i;
          break;
        end
      end
    end
    for (int i = fn; i > pos; i--) begin
      fs[i] = fs[i-1];
      fe[i] = fe[i-1];
    end
    fs[pos] = 16'(s);
    fe[pos] = 16'(e);
    fn++;
  endtask

  task automatic used_place(input int s, input int e, input logic [7:0] o);
    int pos;
    pos = un;
    for (int i = 0; i < un; i++) begin
      if (int'(us[i]) > s) begin
        pos = i;
        break;
      end
    end
    for (int i = un; i > pos; i--) begin
      us[i] = us[i-1];
      ue[i] = ue[i-1];
      uo[i] = uo[i-1];
    end
    us[pos] = 16'(s);
    ue[pos] = 16'(e);
    uo[pos] = o;
    un++;
  endtask

  task automatic merge_free();
    int j, n;
    logic [15:0] s, e;
    for (int i = 1; i < fn; i++) begin
      s = fs[i];
      e = fe[i];
      j = i;
      while (j > 0 && fs[j-1] > s) begin
        fs[j] = fs[j-1];
        fe[j] = fe[j-1];
        j--;
      end
      fs[j] = s;
      fe[j] = e;
    end
    if (fn != 0) begin
      n = 0;
      for (int i = 1; i < fn; i++) begin
        if (int'(fe[n]) + 1 == int'(fs[i])) begin
          fe[n] = fe[i];
        end else begin
          n++;
          fs[n] = fs[i];
          fe[n] = fe[i];
        end
      end
      fn = n + 1;
    end
  endtask

  task automatic predict_extent(input logic [1:0] op, input logic [7:0] pid,
                                input logic [16:0] req, output extent_result_t r);
    int  idx, s, e, oe, ps;
    bit  found;
    found = 0;
    idx = 0;
    r = '0;
    r.status = ST_OK;
    case (op)
      OP_ALLOC: begin
        for (int i = 0; i < fn; i++) begin
          if (req != 0 && int'(fe[i]) - int'(fs[i]) + 1 >= int'(req)) begin
            found = 1;
            idx = i;
            break;
          end
        end
        if (!found) begin
          r.status = ST_NO_FIT;
        end else if (un >= NEXT) begin
          r.status = ST_FULL;
        end else begin
          s = int'(fs[idx]);
          oe = int'(fe[idx]);
          e = s + int'(req) - 1;
          for (int i = idx; i + 1 < fn; i++) begin
            fs[i] = fs[i+1];
            fe[i] = fe[i+1];
          end
          fn--;
          used_place(s, e, pid);
          if (e != oe) free_place(e + 1, oe);
          r.bstart = 16'(s);
          r.bend = 16'(e);
        end
      end
      OP_RELEASE: begin
        for (int i = 0; i < un; i++) begin
          if (uo[i] == pid) begin
            found = 1;
            idx = i;
            break;
          end
        end
        if (!found) begin
          r.status = ST_NO_PID;
        end else if (fn >= NEXT) begin
          r.status = ST_FULL;
        end else begin
          s = int'(us[idx]);
          e = int'(ue[idx]);
          for (int i = idx; i + 1 < un; i++) begin
            us[i] = us[i+1];
            ue[i] = ue[i+1];
            uo[i] = uo[i+1];
          end
          un--;
          free_place(s, e);
          r.bstart = 16'(s);
          r.bend = 16'(e);
        end
      end
      OP_COALESCE: merge_free();
      default: begin
        ps = (psize > 17'd65536) ? 65536 : int'(psize);
        un = 0;
        fn = 0;
        if (ps != 0) begin
          fs[0] = '0;
          fe[0] = 16'(ps - 1);
          fn = 1;
        end
      end
    endcase
    r.nfree = 6'(fn);
    r.nused = 6'(un);
  endtask

  // Inputs only move at the rising edge, so values seen at the falling edge
  // are the ones the block samples at the next rising edge.
  always @(negedge clk_i or negedge rst_ni) begin
    extent_result_t want, got;
    if (!rst_ni) begin
      fn = 0;
      un = 0;
      psize = PSIZE_RESET;
      best_fit = 1'b0;
      fails = 0;
      result_q.delete();
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        if (paddr_i == REG_PSIZE) psize = pwdata_i[16:0];
        else if (paddr_i == REG_POLICY) best_fit = pwdata_i[0];
      end
      if (m_tvalid_i && m_tready_i) begin
        got.status = m_tuser_i;
        got.bstart = m_tdata_i[15:0];
        got.bend   = m_tdata_i[31:16];
        got.nfree  = m_tdata_i[37:32];
        got.nused  = m_tdata_i[43:38];
        if (result_q.size() == 0) begin
          report("unexpected result, status", -1, int'(got.status));
        end else begin
          want = result_q.pop_front();
          if (got.status != want.status)
            report("status", int'(want.status), int'(got.status));
          if (got.bstart != want.bstart)
            report("block_start", int'(want.bstart), int'(got.bstart));
          if (got.bend != want.bend)
            report("block_end", int'(want.bend), int'(got.bend));
          if (got.nfree != want.nfree)
            report("free_count", int'(want.nfree), int'(got.nfree));
          if (got.nused != want.nused)
            report("alloc_count", int'(want.nused), int'(got.nused));
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        predict_extent(s_tuser_i, s_tdata_i[7:0], s_tdata_i[24:8], want);
        result_q.push_back(want);
      end
    end
  end

endmodule

// ----- tb/sv/free_list_block_allocator_top_test.sv -----
// Top of the free list block allocator testbench: clock, reset, stimulus, verdict.
`timescale 1ns / 1ps
module free_list_block_allocator_top_test import fla_pkg::*; ();

  // Worst item is a coalesce (insertion sort, then merge pass) plus long receiver stalls;
  // the limit is several times the slowest correct run.
  localparam int CYCLE_LIMIT = 3000000;
  localparam int DRAIN_WAIT  = 800;   // settle wait in set_pool and before the verdict
  localparam int ITEMS_PHASE = 450;

  logic        clk_i;
  logic        rst_ni;
  logic        psel, penable, pwrite, pready;
  logic [2:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic        s_axis_tvalid, s_axis_tready;
  logic [31:0] s_axis_tdata;   // pid[7:0], request_size[24:8], zeros
  logic [1:0]  s_axis_tuser;   // operation
  logic        m_axis_tvalid, m_axis_tready;
  logic [47:0] m_axis_tdata;   // block_start, block_end, free_count, alloc_count
  logic [1:0]  m_axis_tuser;   // status

  int          fail_count, pending;
  int          cycles;
  int          send_idle, recv_idle;
  int          hold_cnt;
  bit          hold_req;
  int          items_sent;
  int          op_seen [4];
  logic [16:0] cur_psize;

  free_list_block_allocator_top u_dut (
    .clk_i, .rst_ni,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  free_list_block_allocator_checker u_checker (
    .clk_i, .rst_ni,
    .psel_i(psel), .penable_i(penable), .pwrite_i(pwrite), .paddr_i(paddr),
    .pwdata_i(pwdata), .pready_i(pready),
    .s_tvalid_i(s_axis_tvalid), .s_tready_i(s_axis_tready),
    .s_tdata_i(s_axis_tdata), .s_tuser_i(s_axis_tuser),
    .m_tvalid_i(m_axis_tvalid), .m_tready_i(m_axis_tready),
    .m_tdata_i(m_axis_tdata), .m_tuser_i(m_axis_tuser),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Watchdog on a plain cycle count.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Receiver: random back-pressure, plus a long hold when asked for.
  always @(posedge clk_i) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_cnt = 3000;
    end
    if (hold_cnt > 0) begin
      hold_cnt = hold_cnt - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // Setup cycle, then access cycle; the write lands at the access edge.
  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Called with the block idle: every result in, then the sequencer settles.
  task automatic set_pool(input logic [16:0] size, input logic policy);
    wait (pending == 0);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    apb_write(REG_PSIZE, {15'd0, size});
    apb_write(REG_POLICY, {31'd0, policy});
    cur_psize = size;
  endtask

  // Leaves tvalid high after the accepting edge; the next call or the
  // caller lowers it, so there is never a low-then-high in one step.
  task automatic send_item(input logic [1:0] op, input logic [7:0] pid,
                           input logic [16:0] req);
    if ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < send_idle) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {7'd0, req, pid};
    @(negedge clk_i);
    while (!s_axis_tready) @(negedge clk_i);
    @(posedge clk_i);
    items_sent++;
    op_seen[op]++;
  endtask

  function automatic logic [16:0] pick_size();
    int span, pick;
    span = (cur_psize > 17'd65536) ? 65536 : int'(cur_psize);
    pick = $urandom_range(99);
    if (pick < 3)  return 17'd0;
    if (pick < 8)  return 17'($urandom_range(131071));
    if (pick < 40) return 17'($urandom_range(1, 4));
    return 17'($urandom_range(1, span / 8 + 1));
  endfunction

  function automatic logic [7:0] pick_pid();
    if ($urandom_range(9) == 0) return 8'($urandom_range(255));
    return 8'($urandom_range(15));
  endfunction

  // Random traffic as runs: allocate bursts, release bursts, mixed noise.
  task automatic random_items(input int count, input bit with_pressure);
    int done, n, kind;
    logic [7:0] base;
    done = 0;
    while (done < count) begin
      kind = $urandom_range(99);
      n = $urandom_range(3, 40);
      base = 8'($urandom_range(15));
      for (int i = 0; i < n && done < count; i++) begin
        if (kind < 40) begin
          send_item(OP_ALLOC, base + 8'(i % 16), pick_size());
        end else if (kind < 70) begin
          send_item(OP_RELEASE, base + 8'(i % 16), 17'($urandom_range(131071)));
        end else begin
          case ($urandom_range(19))
            0:       send_item(OP_INIT, pick_pid(), 17'($urandom_range(131071)));
            1, 2:    send_item(OP_COALESCE, pick_pid(), 17'($urandom_range(131071)));
            3, 4, 5, 6, 7, 8: send_item(OP_RELEASE, pick_pid(), pick_size());
            default: send_item(OP_ALLOC, pick_pid(), pick_size());
          endcase
        end
        done++;
        if (with_pressure && done == count / 3) hold_req = 1'b1;
        if (with_pressure && done == 2 * count / 3) begin
          // sender pause until the pipe is empty
          s_axis_tvalid <= 1'b0;
          @(posedge clk_i);
          wait (pending == 0);
          @(posedge clk_i);
        end
      end
    end
  endtask

  initial begin
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    s_axis_tvalid = 1'b0; s_axis_tdata = '0; s_axis_tuser = OP_ALLOC;
    m_axis_tready = 1'b0;
    cycles = 0; hold_cnt = 0; hold_req = 1'b0; items_sent = 0;
    foreach (op_seen[i]) op_seen[i] = 0;
    cur_psize = PSIZE_RESET;
    send_idle = 25;
    recv_idle = 64;
    rst_ni = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty pool, extremes of the request, single full-size extent.
    set_pool(17'd65536, 1'b0);
    send_item(OP_ALLOC, 8'd1, 17'd10);        // before initialize: no fit
    send_item(OP_RELEASE, 8'd1, 17'd0);       // nobody owns anything
    send_item(OP_COALESCE, 8'd0, 17'd0);      // empty table
    send_item(OP_INIT, 8'd0, 17'd0);
    send_item(OP_ALLOC, 8'd7, 17'd0);         // zero request
    send_item(OP_ALLOC, 8'd7, 17'd65537);     // larger than the pool
    send_item(OP_ALLOC, 8'd255, 17'd65536);   // whole partition
    send_item(OP_ALLOC, 8'd3, 17'd1);         // nothing left
    send_item(OP_RELEASE, 8'd255, 17'd131071);
    send_item(OP_COALESCE, 8'd0, 17'd0);
    send_item(OP_ALLOC, 8'd0, 17'd1);         // pid zero
    send_item(OP_ALLOC, 8'd2, 17'd100);
    send_item(OP_ALLOC, 8'd170, 17'd131071);
    send_item(OP_ALLOC, 8'd85, 17'd21845);
    send_item(OP_RELEASE, 8'd0, 17'd0);
    send_item(OP_RELEASE, 8'd2, 17'd0);
    send_item(OP_COALESCE, 8'd0, 17'd0);
    send_item(OP_RELEASE, 8'd85, 17'd0);
    send_item(OP_COALESCE, 8'd255, 17'd0);
    send_item(OP_INIT, 8'd0, 17'd0);
    random_items(ITEMS_PHASE, 1'b0);
    s_axis_tvalid <= 1'b0;

    // Small pool, best fit, the other idling mix, long receiver hold.
    send_idle = 64;
    recv_idle = 25;
    set_pool(17'd200, 1'b1);
    send_item(OP_INIT, 8'd0, 17'd0);
    random_items(ITEMS_PHASE, 1'b1);
    s_axis_tvalid <= 1'b0;

    // No idling; saturating, tiny, zero and power-of-two pool sizes.
    send_idle = 0;
    recv_idle = 0;
    set_pool(17'd131071, 1'b1);
    send_item(OP_INIT, 8'd0, 17'd0);
    random_items(ITEMS_PHASE / 4, 1'b0);
    s_axis_tvalid <= 1'b0;
    set_pool(17'd1, 1'b0);
    send_item(OP_INIT, 8'd0, 17'd0);
    random_items(ITEMS_PHASE / 8, 1'b0);
    s_axis_tvalid <= 1'b0;
    set_pool(17'd0, 1'b1);
    send_item(OP_INIT, 8'd0, 17'd0);
    random_items(ITEMS_PHASE / 8, 1'b0);
    s_axis_tvalid <= 1'b0;
    set_pool(17'd64, 1'b0);
    send_item(OP_INIT, 8'd0, 17'd0);
    random_items(ITEMS_PHASE / 2, 1'b0);
    s_axis_tvalid <= 1'b0;

    wait (pending == 0);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    $display("covered %0d items: %0d allocate, %0d release, %0d coalesce, %0d init",
             items_sent, op_seen[OP_ALLOC], op_seen[OP_RELEASE],
             op_seen[OP_COALESCE], op_seen[OP_INIT]);
    $display("pool sizes 0 to above 2^16 in FIFO and best-fit order, %0d cycles",
             cycles);
    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
